// File: hdl/joystick_to_differential_drive_macros.svh
// Assertion macros used by the joystick mixer top level.
`ifndef JOYSTICK_TO_DIFFERENTIAL_DRIVE_MACROS_SVH
`define JOYSTICK_TO_DIFFERENTIAL_DRIVE_MACROS_SVH
`ifndef SYNTH
`define JDD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define JDD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JDD_ASSERT(lbl, prop, msg)
`define JDD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hdl/jdd_pkg.sv
// Types and constants of the joystick differential drive mixer.
package jdd_pkg;
	localparam int STICK_W  = 16;
	localparam int OFF_W    = STICK_W + 1;
	localparam int BAND_W   = 15;
	localparam int DUTY_W   = 7;
	localparam int CELLS    = DUTY_W;
	localparam int NUM_W    = BAND_W + DUTY_W;
	localparam int DSH_W    = BAND_W + DUTY_W - 1;
	localparam int IN_W     = 48;
	localparam int OUT_W    = 24;
	localparam int ADDR_W   = 4;

	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_BACK = 2'd2;

	localparam logic [7:0]        SWITCH_OFF = 8'hE8;
	localparam logic [DUTY_W-1:0] FULL_DUTY  = 7'd100;

	localparam logic [1:0] REG_RIGHT_CENTER = 2'd0;
	localparam logic [1:0] REG_LEFT_CENTER  = 2'd1;
	localparam logic [1:0] REG_DEAD_BAND    = 2'd2;
	localparam logic [1:0] REG_MAX_OFFSET   = 2'd3;

	typedef struct packed {
		logic [STICK_W-1:0] right_center;
		logic [STICK_W-1:0] left_center;
		logic [BAND_W-1:0]  dead_band;
		logic [BAND_W-1:0]  max_offset;
	} cfg_t;

	typedef struct packed {
		logic [NUM_W-1:0]  rem;
		logic [DSH_W-1:0]  dsh;
		logic [DUTY_W-1:0] quo;
		logic [1:0]        adir;
		logic [1:0]        bdir;
		logic              led;
		logic              laser;
		logic              full;
	} cell_t;
endpackage

// File: hdl/jdd_front.sv
// Offset, dead band, branch select, clamp and percent scaling ahead of the divider.
module jdd_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         ce,
	input  logic                         in_vld,
	input  logic [jdd_pkg::STICK_W-1:0]  right_stick,
	input  logic [jdd_pkg::STICK_W-1:0]  left_stick,
	input  logic [7:0]                   led_switch_byte,
	input  logic [7:0]                   laser_switch_byte,
	input  jdd_pkg::cfg_t                cfg,
	output logic                         out_vld,
	output jdd_pkg::cell_t               out_cell
);
	logic                             vld_s1, vld_s2, vld_s3;
	logic signed [jdd_pkg::OFF_W-1:0] roff_s1, loff_s1;
	logic                             led_s1, laser_s1, led_s2, laser_s2, led_s3, laser_s3;
	logic [jdd_pkg::STICK_W-1:0]      rabs_s2, labs_s2;
	logic                             rneg_s2, lneg_s2;
	logic [jdd_pkg::STICK_W-1:0]      mag_s3;
	logic                             mov_s3;
	logic [1:0]                       adir_s3, bdir_s3;

	logic signed [jdd_pkg::OFF_W-1:0] rneg_v, lneg_v;
	logic [jdd_pkg::STICK_W-1:0]      dz, sel_abs, mag_n;
	logic                             rmov, lmov;
	logic [1:0]                       adir_n, bdir_n;
	logic [jdd_pkg::BAND_W-1:0]       clamped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			out_vld <= 1'b0;
		end else if (ce) begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			out_vld <= vld_s3;
		end
	end

	// stage 1: exact signed offsets
	always_ff @(posedge clk) begin
		if (ce) begin
			roff_s1  <= $signed({1'b0, right_stick}) - $signed({1'b0, cfg.right_center});
			loff_s1  <= $signed({1'b0, left_stick}) - $signed({1'b0, cfg.left_center});
			led_s1   <= (led_switch_byte != jdd_pkg::SWITCH_OFF);
			laser_s1 <= (laser_switch_byte != jdd_pkg::SWITCH_OFF);
		end
	end

	// stage 2: magnitudes
	assign rneg_v = -roff_s1;
	assign lneg_v = -loff_s1;

	always_ff @(posedge clk) begin
		if (ce) begin
			rneg_s2  <= roff_s1[jdd_pkg::OFF_W-1];
			lneg_s2  <= loff_s1[jdd_pkg::OFF_W-1];
			rabs_s2  <= roff_s1[jdd_pkg::OFF_W-1] ? rneg_v[jdd_pkg::STICK_W-1:0]
			                                      : roff_s1[jdd_pkg::STICK_W-1:0];
			labs_s2  <= loff_s1[jdd_pkg::OFF_W-1] ? lneg_v[jdd_pkg::STICK_W-1:0]
			                                      : loff_s1[jdd_pkg::STICK_W-1:0];
			led_s2   <= led_s1;
			laser_s2 <= laser_s1;
		end
	end

	// stage 3: priority select and dead band removal
	assign dz      = {1'b0, cfg.dead_band};
	assign rmov    = rabs_s2 > dz;
	assign lmov    = labs_s2 > dz;
	assign sel_abs = rmov ? rabs_s2 : labs_s2;
	assign mag_n   = sel_abs - dz;

	always_comb begin
		adir_n = jdd_pkg::DIR_STOP;
		bdir_n = jdd_pkg::DIR_STOP;
		if (rmov) begin
			adir_n = rneg_s2 ? jdd_pkg::DIR_BACK : jdd_pkg::DIR_FWD;
			bdir_n = adir_n;
		end else if (lmov) begin
			adir_n = lneg_s2 ? jdd_pkg::DIR_BACK : jdd_pkg::DIR_FWD;
			bdir_n = lneg_s2 ? jdd_pkg::DIR_FWD : jdd_pkg::DIR_BACK;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			mov_s3   <= rmov | lmov;
			mag_s3   <= (rmov | lmov) ? mag_n : '0;
			adir_s3  <= adir_n;
			bdir_s3  <= bdir_n;
			led_s3   <= led_s2;
			laser_s3 <= laser_s2;
		end
	end

	// stage 4: clamp and times one hundred
	assign clamped = (mag_s3 > {1'b0, cfg.max_offset}) ? cfg.max_offset
	                                                   : mag_s3[jdd_pkg::BAND_W-1:0];

	always_ff @(posedge clk) begin
		if (ce) begin
			out_cell.rem   <= jdd_pkg::NUM_W'(clamped) * jdd_pkg::NUM_W'(jdd_pkg::FULL_DUTY);
			out_cell.dsh   <= {cfg.max_offset, (jdd_pkg::DUTY_W-1)'(0)};
			out_cell.quo   <= '0;
			out_cell.adir  <= adir_s3;
			out_cell.bdir  <= bdir_s3;
			out_cell.led   <= led_s3;
			out_cell.laser <= laser_s3;
			out_cell.full  <= mov_s3 && (cfg.max_offset == '0);
		end
	end
endmodule

// File: hdl/jdd_div_cell.sv
// One restoring division cell: yields one quotient bit and passes on to the next cell.
module jdd_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           ce,
	input  logic           in_vld,
	input  jdd_pkg::cell_t in_cell,
	output logic           out_vld,
	output jdd_pkg::cell_t out_cell
);
	logic ge;

	assign ge = in_cell.rem >= jdd_pkg::NUM_W'(in_cell.dsh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (ce) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			out_cell.rem   <= ge ? in_cell.rem - jdd_pkg::NUM_W'(in_cell.dsh) : in_cell.rem;
			out_cell.dsh   <= in_cell.dsh >> 1;
			out_cell.quo   <= {in_cell.quo[jdd_pkg::DUTY_W-2:0], ge};
			out_cell.adir  <= in_cell.adir;
			out_cell.bdir  <= in_cell.bdir;
			out_cell.led   <= in_cell.led;
			out_cell.laser <= in_cell.laser;
			out_cell.full  <= in_cell.full;
		end
	end
endmodule

// File: hdl/joystick_to_differential_drive.sv
// Top level of the joystick differential drive mixer.
// Takes one stick sample per clock, unless the output skid stage is occupied, and returns one
// motor command per sample through twelve register stages counting the one that takes
// it: four front stages, seven divider cells, one output register; every stage is
// pipelined, so one item per cycle while the skid stage is empty, and the seven-cell
// quotient chain, one bit per cell, sets the depth.
// The input ready is registered: it drops only while the output skid stage is occupied.
// Registers at byte addresses 0x0 right_center, 0x4 left_center, 0x8 dead_band,
// 0xC max_offset; write them only while no request is in flight.
`include "joystick_to_differential_drive_macros.svh"
module joystick_to_differential_drive (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [jdd_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// right_stick[15:0], left_stick[31:16], led_switch_byte[39:32], laser_switch_byte[47:40]
	input  logic [jdd_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// motor_a_dir[1:0], motor_a_duty[8:2], motor_b_dir[10:9], motor_b_duty[17:11],
	// led_on[18], fire_laser[19], zero[23:20]
	output logic [jdd_pkg::OUT_W-1:0]   m_axis_tdata
);
	jdd_pkg::cfg_t               cfg_q;
	logic                        ce;
	logic [jdd_pkg::CELLS:0]     chain_vld;
	jdd_pkg::cell_t              chain_d [jdd_pkg::CELLS+1];
	jdd_pkg::cell_t              last;
	logic [jdd_pkg::DUTY_W-1:0]  duty;
	logic [jdd_pkg::OUT_W-1:0]   res;
	logic [jdd_pkg::OUT_W-1:0]   out_q, skid_q;
	logic                        ov_q, kv_q;
	logic                        wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.right_center <= 16'd1500;
			cfg_q.left_center  <= 16'd1500;
			cfg_q.dead_band    <= 15'd50;
			cfg_q.max_offset   <= 15'd450;
		end else if (wr) begin
			unique case (paddr[3:2])
				jdd_pkg::REG_RIGHT_CENTER: cfg_q.right_center <= pwdata[15:0];
				jdd_pkg::REG_LEFT_CENTER:  cfg_q.left_center  <= pwdata[15:0];
				jdd_pkg::REG_DEAD_BAND:    cfg_q.dead_band    <= pwdata[14:0];
				jdd_pkg::REG_MAX_OFFSET:   cfg_q.max_offset   <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			jdd_pkg::REG_RIGHT_CENTER: prdata = {16'd0, cfg_q.right_center};
			jdd_pkg::REG_LEFT_CENTER:  prdata = {16'd0, cfg_q.left_center};
			jdd_pkg::REG_DEAD_BAND:    prdata = {17'd0, cfg_q.dead_band};
			jdd_pkg::REG_MAX_OFFSET:   prdata = {17'd0, cfg_q.max_offset};
			default:                   prdata = '0;
		endcase
	end

	assign ce            = ~kv_q;
	assign s_axis_tready = ce;

	jdd_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.ce                (ce),
		.in_vld            (s_axis_tvalid),
		.right_stick       (s_axis_tdata[15:0]),
		.left_stick        (s_axis_tdata[31:16]),
		.led_switch_byte   (s_axis_tdata[39:32]),
		.laser_switch_byte (s_axis_tdata[47:40]),
		.cfg               (cfg_q),
		.out_vld           (chain_vld[0]),
		.out_cell          (chain_d[0])
	);

	for (genvar i = 0; i < jdd_pkg::CELLS; i++) begin : g_cell
		jdd_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ce       (ce),
			.in_vld   (chain_vld[i]),
			.in_cell  (chain_d[i]),
			.out_vld  (chain_vld[i+1]),
			.out_cell (chain_d[i+1])
		);
	end

	// a stop carries no duty, even when a zero max_offset leaves the quotient meaningless
	assign last = chain_d[jdd_pkg::CELLS];
	assign duty = last.full ? jdd_pkg::FULL_DUTY
	            : (last.adir == jdd_pkg::DIR_STOP) ? '0 : last.quo;
	assign res  = {4'd0, last.laser, last.led, duty, last.bdir, duty, last.adir};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			kv_q <= 1'b0;
		end else if (ov_q && !m_axis_tready) begin
			if (ce && chain_vld[jdd_pkg::CELLS]) begin
				kv_q <= 1'b1;
			end
		end else if (kv_q) begin
			ov_q <= 1'b1;
			kv_q <= 1'b0;
		end else begin
			ov_q <= chain_vld[jdd_pkg::CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (ov_q && !m_axis_tready) begin
			if (ce) begin
				skid_q <= res;
			end
		end else if (kv_q) begin
			out_q <= skid_q;
		end else begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = out_q;

	`JDD_ASSERT(a_skid_implies_out, kv_q |-> ov_q, "skid full with empty output")
	`JDD_ASSERT(a_duty_range, ov_q |-> (out_q[8:2] <= jdd_pkg::FULL_DUTY), "duty above 100")
	`JDD_ASSERT(a_stop_zero, (ov_q && out_q[1:0] == jdd_pkg::DIR_STOP) |-> (out_q[8:2] == '0 && out_q[10:9] == jdd_pkg::DIR_STOP), "stop with nonzero duty")
	`JDD_ASSERT(a_same_duty, ov_q |-> (out_q[8:2] == out_q[17:11]), "motor duties differ")
	`JDD_ASSERT(a_dir_code, ov_q |-> (out_q[1:0] != 2'd3 && out_q[10:9] != 2'd3), "bad direction code")
endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the joystick differential drive mixer.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import jdd_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE      = 16;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_REQS  = 175;

	typedef struct packed {
		logic [7:0]         laser_switch;
		logic [7:0]         led_switch;
		logic [STICK_W-1:0] left_stick;
		logic [STICK_W-1:0] right_stick;
	} stick_sample_t;

	typedef struct packed {
		logic [3:0]        pad;
		logic              fire_laser;
		logic              led_on;
		logic [DUTY_W-1:0] b_duty;
		logic [1:0]        b_dir;
		logic [DUTY_W-1:0] a_duty;
		logic [1:0]        a_dir;
	} drive_cmd_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;

	logic [STICK_W-1:0] right_center_r = 16'd1500;
	logic [STICK_W-1:0] left_center_r  = 16'd1500;
	logic [BAND_W-1:0]  dead_band_r    = 15'd50;
	logic [BAND_W-1:0]  max_offset_r   = 15'd450;

	stick_sample_t sample_q[$];
	drive_cmd_t    cmd_expect_q[$];
	int            send_idle_pct = 24;
	int            recv_idle_pct = 24;
	int            errors = 0;
	int            idle_cycles = 0;

	joystick_to_differential_drive u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [DUTY_W-1:0] duty_for(int mag);
		int lim;
		lim = int'(max_offset_r);
		if (lim == 0)
			return FULL_DUTY;
		if (mag > lim)
			mag = lim;
		return DUTY_W'((mag * int'(FULL_DUTY)) / lim);
	endfunction

	function automatic drive_cmd_t mix_drive(stick_sample_t s);
		drive_cmd_t c;
		int roff, loff, dz;
		c = '0;
		roff = int'(s.right_stick) - int'(right_center_r);
		loff = int'(s.left_stick) - int'(left_center_r);
		dz = int'(dead_band_r);
		if (roff > dz) begin
			c.a_dir = DIR_FWD;
			c.b_dir = DIR_FWD;
			c.a_duty = duty_for(roff - dz);
		end else if (roff < -dz) begin
			c.a_dir = DIR_BACK;
			c.b_dir = DIR_BACK;
			c.a_duty = duty_for(-roff - dz);
		end else if (loff > dz) begin
			c.a_dir = DIR_FWD;
			c.b_dir = DIR_BACK;
			c.a_duty = duty_for(loff - dz);
		end else if (loff < -dz) begin
			c.a_dir = DIR_BACK;
			c.b_dir = DIR_FWD;
			c.a_duty = duty_for(-loff - dz);
		end
		c.b_duty = c.a_duty;
		c.led_on = (s.led_switch != SWITCH_OFF);
		c.fire_laser = (s.laser_switch != SWITCH_OFF);
		return c;
	endfunction

	function automatic logic [STICK_W-1:0] near_center(logic [STICK_W-1:0] ctr, int span);
		int v;
		v = int'(ctr) + int'($urandom_range(0, 2 * span)) - span;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return STICK_W'(v);
	endfunction

	function automatic logic [7:0] switch_byte();
		if ($urandom_range(0, 2) == 0)
			return SWITCH_OFF;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic stick_sample_t random_sample();
		stick_sample_t s;
		int span, dz, sel;
		dz = int'(dead_band_r);
		span = dz + int'(max_offset_r) + int'(max_offset_r) / 4 + 16;
		sel = $urandom_range(0, 9);
		if (sel < 3) begin
			s.right_stick = 16'($urandom);
			s.left_stick = 16'($urandom);
		end else begin
			// right stick inside the band lets the turn branches win
			if (sel < 6)
				s.right_stick = near_center(right_center_r, dz);
			else
				s.right_stick = near_center(right_center_r, span);
			s.left_stick = near_center(left_center_r, span);
		end
		s.led_switch = switch_byte();
		s.laser_switch = switch_byte();
		return s;
	endfunction

	task automatic push_sample(input int r, input int l, input int led, input int laser);
		stick_sample_t s;
		s.right_stick = r[15:0];
		s.left_stick = l[15:0];
		s.led_switch = led[7:0];
		s.laser_switch = laser[7:0];
		sample_q.push_back(s);
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read_check(input logic [ADDR_W-1:0] addr, input logic [31:0] want);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			errors++;
			$display("%0t readback addr 0x%0h expected 0x%0h actual 0x%0h",
				$time, addr, want, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input int rc, input int lc, input int db, input int mo);
		right_center_r = STICK_W'(rc);
		left_center_r = STICK_W'(lc);
		dead_band_r = BAND_W'(db);
		max_offset_r = BAND_W'(mo);
		// junk in the upper bits must be dropped by the register
		apb_write({REG_RIGHT_CENTER, 2'b00}, ($urandom & 32'hFFFF_0000) | 32'(right_center_r));
		apb_read_check({REG_RIGHT_CENTER, 2'b00}, 32'(right_center_r));
		apb_write({REG_LEFT_CENTER, 2'b00}, ($urandom & 32'hFFFF_0000) | 32'(left_center_r));
		apb_read_check({REG_LEFT_CENTER, 2'b00}, 32'(left_center_r));
		apb_write({REG_DEAD_BAND, 2'b00}, ($urandom & 32'hFFFF_8000) | 32'(dead_band_r));
		apb_read_check({REG_DEAD_BAND, 2'b00}, 32'(dead_band_r));
		apb_write({REG_MAX_OFFSET, 2'b00}, ($urandom & 32'hFFFF_8000) | 32'(max_offset_r));
		apb_read_check({REG_MAX_OFFSET, 2'b00}, 32'(max_offset_r));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (sample_q.size() != 0 || s_axis_tvalid || cmd_expect_q.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// request driver and prediction at acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				cmd_expect_q.push_back(mix_drive(s_axis_tdata));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_axis_tdata <= sample_q.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : result_mon
		drive_cmd_t got, want;
		m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (cmd_expect_q.size() == 0) begin
				errors++;
				$display("%0t unexpected result expected none actual 0x%0h", $time, got);
			end else begin
				want = cmd_expect_q.pop_front();
				check_field("motor_a_dir", want.a_dir, got.a_dir);
				check_field("motor_a_duty", want.a_duty, got.a_duty);
				check_field("motor_b_dir", want.b_dir, got.b_dir);
				check_field("motor_b_duty", want.b_duty, got.b_duty);
				check_field("led_on", want.led_on, got.led_on);
				check_field("fire_laser", want.fire_laser, got.fire_laser);
				check_field("pad", want.pad, got.pad);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values: center 1500, band 50, max 450
		push_sample(1500, 1500, 8'hE8, 8'hE8);
		push_sample(1550, 1500, 8'h00, 8'hFF);
		push_sample(1551, 1500, 8'hFF, 8'h00);
		push_sample(1450, 1500, 8'hE9, 8'h68);
		push_sample(1449, 1500, 8'h68, 8'hE9);
		push_sample(2000, 1500, 8'hE8, 8'h17);
		push_sample(65535, 1500, 8'h17, 8'hE8);
		push_sample(1000, 1500, 8'hE8, 8'hE8);
		push_sample(0, 1500, 8'hE8, 8'hE8);
		push_sample(1725, 1500, 8'hE8, 8'hE8);
		push_sample(1500, 1551, 8'hE8, 8'hE8);
		push_sample(1500, 1449, 8'hE8, 8'hE8);
		push_sample(1500, 65535, 8'hE8, 8'hE8);
		push_sample(1500, 0, 8'hE8, 8'hE8);
		push_sample(1520, 1800, 8'hE8, 8'hE8);
		push_sample(1800, 0, 8'hE8, 8'hE8);
		push_sample(1200, 65535, 8'hE8, 8'hE8);
		wait_drained();

		set_config(0, 65535, 0, 1);
		push_sample(0, 65535, 8'hE8, 8'hE8);
		push_sample(1, 65535, 8'hE8, 8'hE8);
		push_sample(0, 65534, 8'hE8, 8'hE8);
		push_sample(65535, 0, 8'hE8, 8'hE8);
		wait_drained();

		set_config(65535, 0, 32767, 32767);
		push_sample(0, 0, 8'hE8, 8'hE8);
		push_sample(32767, 0, 8'hE8, 8'hE8);
		push_sample(32768, 32767, 8'hE8, 8'hE8);
		push_sample(32768, 32768, 8'hE8, 8'hE8);
		push_sample(32768, 65535, 8'hE8, 8'hE8);
		wait_drained();

		// zero max_offset: anything past the band is full duty
		set_config(1500, 1500, 50, 0);
		push_sample(1551, 1500, 8'hE8, 8'hE8);
		push_sample(1550, 1500, 8'hE8, 8'hE8);
		push_sample(1449, 1500, 8'hE8, 8'hE8);
		push_sample(1500, 1551, 8'hE8, 8'hE8);
		push_sample(1500, 1449, 8'hE8, 8'hE8);
		wait_drained();

		for (int p = 0; p < RAND_PHASES; p++) begin
			if ($urandom_range(0, 3) == 0)
				set_config($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 32767), $urandom_range(1, 32767));
			else
				set_config($urandom_range(1000, 2000), $urandom_range(1000, 2000),
					$urandom_range(0, 200), $urandom_range(1, 1000));
			send_idle_pct = (p == 2) ? 0 : 24;
			recv_idle_pct = (p == 2) ? 0 : 24;
			for (int i = 0; i < PHASE_REQS; i++)
				sample_q.push_back(random_sample());
			wait_drained();
		end

		if (errors == 0 && cmd_expect_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// File: joystick_to_differential_drive.f
+incdir+hdl
hdl/jdd_pkg.sv
hdl/jdd_front.sv
hdl/jdd_div_cell.sv
hdl/joystick_to_differential_drive.sv
dv/tb_top.sv
